### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

### rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Constants, codes and reset tables of the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bpa_pkg;
	localparam int PAGE_COUNT = 16384;
	localparam int TOP_ORDER  = 10;
	localparam int PAGE_W     = $clog2(PAGE_COUNT);
	localparam int NODE_W     = PAGE_W + 1;
	localparam int WORD_W     = 64;
	localparam int WBIT_W     = $clog2(WORD_W);
	localparam int WORDS      = 2 * PAGE_COUNT / WORD_W;
	localparam int WADDR_W    = $clog2(WORDS);
	localparam int CHUNK_W    = 32;
	localparam int CBIT_W     = $clog2(CHUNK_W);
	localparam int CHUNKS     = WORDS / CHUNK_W;
	localparam int CIDX_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int ORD_W      = 5;

	typedef enum logic { FUNC_ALLOC = 1'b0, FUNC_FREE = 1'b1 } func_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_NOTALLOC = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SCAN, S_FIND, S_SPLIT, S_SPLIT_WR, S_ALLOC_PG,
		S_FREE_CHK, S_MERGE_RD, S_MERGE_WR, S_SET_RD, S_SET_WR, S_RESP
	} state_t;

	function automatic logic [WORD_W-1:0] init_word(input int w);
		logic [WORD_W-1:0] r;
		int nid;
		int base;
		base = PAGE_COUNT >> TOP_ORDER;
		for (int b = 0; b < WORD_W; b++) begin
			nid = w * WORD_W + b;
			r[b] = (nid >= base) && (nid < 2 * base);
		end
		return r;
	endfunction

	function automatic logic [WORDS-1:0] init_summary();
		logic [WORDS-1:0] r;
		for (int w = 0; w < WORDS; w++) begin
			r[w] = |init_word(w);
		end
		return r;
	endfunction

	localparam logic [WORDS-1:0] INIT_SUM = init_summary();

	function automatic logic [NODE_W-1:0] node_of(input logic [PAGE_W-1:0] pg,
			input logic [ORD_W-1:0] k);
		return (NODE_W'(PAGE_COUNT) >> k) + (NODE_W'(pg) >> k);
	endfunction

	function automatic logic [CIDX_W-1:0] first_chunk(input logic [ORD_W-1:0] k);
		return CIDX_W'((32'(PAGE_COUNT) >> k) >> (WBIT_W + CBIT_W));
	endfunction
endpackage
`default_nettype wire

### rtl/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Buddy page allocator with tree bitmap and page table in synchronous RAM.
// ----------------------------------------------------------------------------
// After reset the block runs an init sweep that clears the page table and
// loads the bitmap; req_ready stays low meanwhile.
// An allocate scans a per-word summary of the bitmap, 32 words a cycle, order
// by order from the request up, then reads the word, splits the block one
// level at a time (a read and a write state per level), records the page and
// loads the response. A free checks the page table, merges with the buddy
// level by level (a read and a write state each), marks the final block and
// loads the response; a page that is not allocated goes straight from the
// check to the response.
// One request is handled at a time; a response waits in an output register.
`default_nettype none
module buddy_page_allocator (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output logic                        req_ready,
	input  wire logic                   func,
	input  wire logic [3:0]             order,
	input  wire logic [bpa_pkg::PAGE_W-1:0] page_index,
	output logic                        rsp_valid,
	input  wire logic                   rsp_ready,
	output logic [1:0]                  status,
	output logic [bpa_pkg::PAGE_W-1:0]  page_number,
	output logic [3:0]                  block_order
);
	import bpa_pkg::*;

	state_t state_q, state_d;
	logic [ORD_W-1:0] k_q, k_d, req_ord_q, req_ord_d;
	logic [CIDX_W-1:0] ci_q, ci_d;
	logic [NODE_W-1:0] node_q, node_d, tgt_q, tgt_d;
	logic [PAGE_W-1:0] page_q, page_d, clr_q, clr_d;
	status_t res_st_q, res_st_d;
	logic [PAGE_W-1:0] res_pg_q, res_pg_d;
	logic [ORD_W-1:0] res_ord_q, res_ord_d;
	logic rsp_valid_q;
	logic [1:0] status_q;
	logic [PAGE_W-1:0] page_number_q;
	logic [3:0] block_order_q;
	logic load_rsp;
	logic [WORDS-1:0] sum_q;

	logic [WORD_W-1:0] bm_mem [WORDS];
	logic [WADDR_W-1:0] bm_raddr, bm_raddr_s1, bm_waddr;
	logic [WORD_W-1:0] bm_rdata_s1, bm_wdata;
	logic bm_we;

	logic [ORD_W:0] pm_mem [PAGE_COUNT];
	logic [PAGE_W-1:0] pm_raddr, pm_waddr;
	logic [ORD_W:0] pm_rdata_s1, pm_wdata;
	logic pm_we;

	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		bm_rdata_s1 <= bm_mem[bm_raddr];
		bm_raddr_s1 <= bm_raddr;
	end

	always_ff @(posedge clk) begin
		if (pm_we) begin
			pm_mem[pm_waddr] <= pm_wdata;
		end
		pm_rdata_s1 <= pm_mem[pm_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			sum_q       <= INIT_SUM;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (bm_we) begin
				sum_q[bm_waddr] <= |bm_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q       <= k_d;
		req_ord_q <= req_ord_d;
		ci_q      <= ci_d;
		node_q    <= node_d;
		tgt_q     <= tgt_d;
		page_q    <= page_d;
		res_st_q  <= res_st_d;
		res_pg_q  <= res_pg_d;
		res_ord_q <= res_ord_d;
		if (load_rsp) begin
			status_q      <= res_st_q;
			page_number_q <= res_pg_q;
			block_order_q <= 4'(res_ord_q);
		end
	end

	always_comb begin
		logic [CHUNK_W-1:0] chunk;
		logic hit;
		int sel;
		int lo_w;
		int hi_w;
		int base;
		int nid;
		int w;
		logic [ORD_W-1:0] held;

		state_d   = state_q;
		k_d       = k_q;
		req_ord_d = req_ord_q;
		ci_d      = ci_q;
		node_d    = node_q;
		tgt_d     = tgt_q;
		page_d    = page_q;
		clr_d     = clr_q;
		res_st_d  = res_st_q;
		res_pg_d  = res_pg_q;
		res_ord_d = res_ord_q;
		load_rsp  = 1'b0;
		req_ready = 1'b0;
		bm_raddr  = bm_raddr_s1;
		bm_we     = 1'b0;
		bm_waddr  = bm_raddr_s1;
		bm_wdata  = bm_rdata_s1;
		pm_raddr  = page_q;
		pm_we     = 1'b0;
		pm_waddr  = page_q;
		pm_wdata  = '0;
		hit       = 1'b0;
		sel       = 0;
		base      = PAGE_COUNT >> k_q;
		lo_w      = base >> WBIT_W;
		hi_w      = (2 * base - 1) >> WBIT_W;
		chunk     = sum_q[ci_q * CHUNK_W +: CHUNK_W];
		held      = pm_rdata_s1[ORD_W-1:0];
		nid       = 0;
		w         = 0;

		unique case (state_q)
			S_INIT: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
				if (32'(clr_q) < WORDS) begin
					bm_we    = 1'b1;
					bm_waddr = WADDR_W'(clr_q);
					bm_wdata = init_word(int'(clr_q));
				end
				clr_d = clr_q + 1'b1;
				if (32'(clr_q) == PAGE_COUNT - 1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				pm_raddr  = page_index;
				if (req_valid) begin
					if (func == FUNC_ALLOC) begin
						if (ORD_W'(order) > ORD_W'(TOP_ORDER)) begin
							res_st_d  = ST_NOFREE;
							res_pg_d  = '0;
							res_ord_d = '0;
							state_d   = S_RESP;
						end else begin
							req_ord_d = ORD_W'(order);
							k_d       = ORD_W'(order);
							ci_d      = first_chunk(ORD_W'(order));
							state_d   = S_SCAN;
						end
					end else begin
						if (32'(page_index) >= PAGE_COUNT) begin
							res_st_d  = ST_NOTALLOC;
							res_pg_d  = '0;
							res_ord_d = '0;
							state_d   = S_RESP;
						end else begin
							page_d  = page_index;
							state_d = S_FREE_CHK;
						end
					end
				end
			end
			S_SCAN: begin
				for (int j = CHUNK_W - 1; j >= 0; j--) begin
					w = int'(ci_q) * CHUNK_W + j;
					if (chunk[j] && w >= lo_w && w <= hi_w) begin
						hit = 1'b1;
						sel = w;
					end
				end
				if (hit) begin
					bm_raddr = WADDR_W'(sel);
					state_d  = S_FIND;
				end else if (int'(ci_q) * CHUNK_W + CHUNK_W - 1 >= hi_w) begin
					if (k_q == ORD_W'(TOP_ORDER)) begin
						res_st_d  = ST_NOFREE;
						res_pg_d  = '0;
						res_ord_d = '0;
						state_d   = S_RESP;
					end else begin
						k_d  = k_q + 1'b1;
						ci_d = first_chunk(k_q + 1'b1);
					end
				end else begin
					ci_d = ci_q + 1'b1;
				end
			end
			S_FIND: begin
				for (int b = WORD_W - 1; b >= 0; b--) begin
					nid = int'(bm_raddr_s1) * WORD_W + b;
					if (bm_rdata_s1[b] && nid >= base && nid < 2 * base) begin
						hit = 1'b1;
						sel = b;
					end
				end
				if (hit) begin
					node_d        = NODE_W'(int'(bm_raddr_s1) * WORD_W + sel);
					bm_we         = 1'b1;
					bm_wdata      = bm_rdata_s1;
					bm_wdata[WBIT_W'(sel)] = 1'b0;
					state_d       = (k_q > req_ord_q) ? S_SPLIT : S_ALLOC_PG;
				end else if (k_q == ORD_W'(TOP_ORDER)) begin
					res_st_d  = ST_NOFREE;
					res_pg_d  = '0;
					res_ord_d = '0;
					state_d   = S_RESP;
				end else begin
					k_d     = k_q + 1'b1;
					ci_d    = first_chunk(k_q + 1'b1);
					state_d = S_SCAN;
				end
			end
			S_SPLIT: begin
				node_d   = {node_q[NODE_W-2:0], 1'b0};
				tgt_d    = {node_q[NODE_W-2:0], 1'b1};
				bm_raddr = WADDR_W'(tgt_d >> WBIT_W);
				k_d      = k_q - 1'b1;
				state_d  = S_SPLIT_WR;
			end
			S_SPLIT_WR: begin
				bm_we                     = 1'b1;
				bm_wdata[tgt_q[WBIT_W-1:0]] = 1'b1;
				state_d = (k_q == req_ord_q) ? S_ALLOC_PG : S_SPLIT;
			end
			S_ALLOC_PG: begin
				res_pg_d  = PAGE_W'((node_q - (NODE_W'(PAGE_COUNT) >> k_q)) << k_q);
				pm_we     = 1'b1;
				pm_waddr  = res_pg_d;
				pm_wdata  = {1'b1, k_q};
				res_st_d  = ST_OK;
				res_ord_d = k_q;
				state_d   = S_RESP;
			end
			S_FREE_CHK: begin
				if (!pm_rdata_s1[ORD_W]) begin
					res_st_d  = ST_NOTALLOC;
					res_pg_d  = '0;
					res_ord_d = '0;
					state_d   = S_RESP;
				end else begin
					pm_we    = 1'b1;
					pm_wdata = {1'b0, held};
					k_d      = (held > ORD_W'(TOP_ORDER)) ? ORD_W'(TOP_ORDER) : held;
					state_d  = (k_d < ORD_W'(TOP_ORDER)) ? S_MERGE_RD : S_SET_RD;
				end
			end
			S_MERGE_RD: begin
				tgt_d    = node_of(page_q ^ (PAGE_W'(1) << k_q), k_q);
				bm_raddr = WADDR_W'(tgt_d >> WBIT_W);
				state_d  = S_MERGE_WR;
			end
			S_MERGE_WR: begin
				if (bm_rdata_s1[tgt_q[WBIT_W-1:0]]) begin
					bm_we                     = 1'b1;
					bm_wdata[tgt_q[WBIT_W-1:0]] = 1'b0;
					page_d  = page_q & ~(PAGE_W'(1) << k_q);
					k_d     = k_q + 1'b1;
					state_d = (k_d < ORD_W'(TOP_ORDER)) ? S_MERGE_RD : S_SET_RD;
				end else begin
					state_d = S_SET_RD;
				end
			end
			S_SET_RD: begin
				tgt_d    = node_of(page_q, k_q);
				bm_raddr = WADDR_W'(tgt_d >> WBIT_W);
				state_d  = S_SET_WR;
			end
			S_SET_WR: begin
				bm_we                     = 1'b1;
				bm_wdata[tgt_q[WBIT_W-1:0]] = 1'b1;
				res_st_d  = ST_OK;
				res_pg_d  = '0;
				res_ord_d = k_q;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign page_number = page_number_q;
	assign block_order = block_order_q;

`include "assert_macros.svh"

	`ASSERT_CLK(a_init_blocks_req, state_q == S_INIT |-> !req_ready, "request taken during init")
	`ASSERT_CLK(a_err_zero, rsp_valid && status != ST_OK |-> page_number == 0 && block_order == 0, "error response carries data")
	`ASSERT_CLK(a_merge_range, state_q == S_MERGE_RD |-> k_q < ORD_W'(TOP_ORDER), "merge beyond top order")
	`ASSERT_CLK(a_split_order, state_q == S_SPLIT |-> k_q > req_ord_q, "split below requested order")
	`ASSERT_NEVER(a_two_writes, bm_we && state_q == S_SCAN, "bitmap written during scan")
endmodule
`default_nettype wire
